### rtl/oidl_pkg.sv
// shared types and constants for the ordered id list table
package oidl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 32;
    localparam int ITEM_ID_W    = 32;
    localparam int STATUS_W     = 3;
    localparam int COUNT_OUT_W  = 5;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_PRESENT   = 3'd4,
        ST_ABSENT    = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [ITEM_ID_W-1:0] item_id;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rsp_t;

endpackage

### rtl/oidl_ram.sv
// entry store: one write port, one registered read port
module oidl_ram #(
    parameter int DEPTH  = oidl_pkg::CAPACITY_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = oidl_pkg::ID_BITS_DEF
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ordered_id_list_table_unit.sv
// ordered id list table: append, remove with gap closing, presence query, clear
//
// Requests arrive on req (req_valid/req_ready), one result per request leaves on
// rsp (rsp_valid/rsp_ready). One request is worked on at a time; req_ready is
// high while the unit is idle, even if the previous result has not been taken.
// Add and clear, and remove or query on an empty list, skip the store walk.
// Remove and query walk the store from position 0, one entry per cycle through
// the single read port of the entry RAM; a remove then shifts every later entry
// down one place, again one entry per cycle, overlapping the read of entry k+1
// with the write of entry k.
// The result sits in an output register; if the receiver stalls, the unit still
// takes the next request and holds its finished result until the register frees.
// Reset empties the list (count zero, no pending result); the store contents
// are left as they are, since only positions below the count are ever read.
// Identifiers are compared on their low ID_BITS bits.
module ordered_id_list_table_unit #(
    parameter int CAPACITY = oidl_pkg::CAPACITY_DEF,
    parameter int ID_BITS  = oidl_pkg::ID_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  oidl_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output oidl_pkg::rsp_t rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    oidl_pkg::state_t  state_reg, state_next;
    oidl_pkg::cmd_t    cmd_reg, cmd_next;
    oidl_pkg::status_t status_reg, status_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               rsp_valid_reg;
    oidl_pkg::rsp_t     rsp_reg;

    logic               accept;
    logic               rsp_free;
    logic               rsp_load;
    logic [ID_BITS-1:0] req_key;
    logic [CNT_W-1:0]   pos_inc;
    logic [CNT_W-1:0]   pos_dec;
    logic               more;
    logic               hit;

    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ID_BITS-1:0] rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ID_BITS-1:0] wr_data;

    oidl_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W),
        .DATA_W (ID_BITS)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign req_ready = (state_reg == oidl_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign req_key   = ID_BITS'(req.item_id);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign pos_inc   = pos_reg + 1'b1;
    assign pos_dec   = pos_reg - 1'b1;
    assign more      = (pos_inc < count_reg);
    // rd_data holds the entry at pos_reg while scanning
    assign hit       = (rd_data == key_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oidl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((req.cmd == oidl_pkg::CMD_REMOVE || req.cmd == oidl_pkg::CMD_QUERY)
                        && count_reg != '0)
                    begin
                        state_next = oidl_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = oidl_pkg::S_RESP;
                    end
                end
            end
            oidl_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    if (cmd_reg == oidl_pkg::CMD_REMOVE && more)
                    begin
                        state_next = oidl_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = oidl_pkg::S_RESP;
                    end
                end
                else if (!more)
                begin
                    state_next = oidl_pkg::S_RESP;
                end
            end
            oidl_pkg::S_SHIFT:
            begin
                if (!more)
                begin
                    state_next = oidl_pkg::S_RESP;
                end
            end
            oidl_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = oidl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oidl_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and store accesses
    always_comb
    begin
        cmd_next    = cmd_reg;
        status_next = status_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        rd_en       = 1'b0;
        rd_addr     = pos_inc[ADDR_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = count_reg[ADDR_W-1:0];
        wr_data     = req_key;
        rsp_load    = 1'b0;
        case (state_reg)
            oidl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = req.cmd;
                    key_next = req_key;
                    case (req.cmd)
                        oidl_pkg::CMD_ADD:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = oidl_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                count_next  = count_reg + 1'b1;
                                status_next = oidl_pkg::ST_ADDED;
                            end
                        end
                        oidl_pkg::CMD_REMOVE,
                        oidl_pkg::CMD_QUERY:
                        begin
                            status_next = (req.cmd == oidl_pkg::CMD_REMOVE) ?
                                          oidl_pkg::ST_NOT_FOUND : oidl_pkg::ST_ABSENT;
                            if (count_reg != '0)
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = '0;
                                pos_next = '0;
                            end
                        end
                        oidl_pkg::CMD_CLEAR:
                        begin
                            count_next  = '0;
                            status_next = oidl_pkg::ST_CLEARED;
                        end
                        default:
                        begin
                            status_next = status_reg;
                        end
                    endcase
                end
            end
            oidl_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    if (cmd_reg == oidl_pkg::CMD_QUERY)
                    begin
                        status_next = oidl_pkg::ST_PRESENT;
                    end
                    else
                    begin
                        status_next = oidl_pkg::ST_REMOVED;
                        if (more)
                        begin
                            rd_en    = 1'b1;
                            pos_next = pos_inc;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                else if (more)
                begin
                    rd_en    = 1'b1;
                    pos_next = pos_inc;
                end
            end
            oidl_pkg::S_SHIFT:
            begin
                // move the entry just read down one place, fetch the next
                wr_en   = 1'b1;
                wr_addr = pos_dec[ADDR_W-1:0];
                wr_data = rd_data;
                if (more)
                begin
                    rd_en    = 1'b1;
                    pos_next = pos_inc;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            oidl_pkg::S_RESP:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oidl_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        if (rsp_load)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.entry_count <= oidl_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
